// ===== sv/rsom_pkg.sv =====
`default_nettype none

package rsom_pkg;

  // Field widths of the pixel stream and the register file
  localparam int PIX_W   = 12;
  localparam int COL_W   = 8;
  localparam int ORG_W   = 14;
  localparam int TRIG_W  = 16;
  localparam int SIZE_W  = 12;
  localparam int KIND_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Datapath widths: offset from origin, one trig product, rotated magnitude, its square
  localparam int DIFF_W = PIX_W + 3;
  localparam int PROD_W = TRIG_W + DIFF_W;
  localparam int MAG_W  = PROD_W;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SSQ_W  = 2 * SIZE_W;

  // Pipeline depth and output buffering
  localparam int PIPE_DEPTH = 7;
  localparam int FIFO_AW    = 4;
  localparam int CREDIT_W   = 4;
  localparam logic [CREDIT_W-1:0] CREDITS = CREDIT_W'(PIPE_DEPTH + 3);

  // Shape codes
  typedef enum logic [KIND_W-1:0] {
    SHAPE_NONE    = 3'd0,
    SHAPE_BAR     = 3'd1,
    SHAPE_CIRCLE  = 3'd2,
    SHAPE_ELLIPSE = 3'd3,
    SHAPE_SQUARE  = 3'd4
  } shape_kind_e;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_KIND = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_COS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_SIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_A     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_B     = 3'd6;

  // Cosine resets to 1.0 in Q1.14
  localparam logic [TRIG_W-1:0] ROT_COS_RESET = 16'd16384;

  typedef struct packed {
    logic [PIX_W-1:0] pix_x;
    logic [PIX_W-1:0] pix_y;
    logic             in_mask;
    logic [COL_W-1:0] in_red;
    logic [COL_W-1:0] in_green;
    logic [COL_W-1:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [COL_W-1:0] out_red;
    logic [COL_W-1:0] out_green;
    logic [COL_W-1:0] out_blue;
    logic             out_mask;
  } pix_out_t;

  typedef struct packed {
    logic [KIND_W-1:0] shape_kind;
    logic [ORG_W-1:0]  origin_x;
    logic [ORG_W-1:0]  origin_y;
    logic [TRIG_W-1:0] rot_cos;
    logic [TRIG_W-1:0] rot_sin;
    logic [SIZE_W-1:0] size_a;
    logic [SIZE_W-1:0] size_b;
  } cfg_t;

endpackage

`default_nettype wire

// ===== sv/rotated_shape_occlusion_mask.sv =====
// Rotated shape occlusion mask.
// Input channel: one pixel item per clock (in_valid_i / in_stall_o, payload in_item_i).
// Output channel: one result item per input item, in order (out_valid_o / out_stall_i,
// payload out_item_o). A masked pixel inside the configured shape, after the move to
// the shape origin and the rotation, comes out black with its mask bit cleared.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i; write
// only while no item is in flight. cfg_ready_o is always high.
// Path: each accepted item passes the 7 pipeline stages and then the output buffer
// before the receiver can take its result.
// Throughput: one item per cycle while in_stall_o is low, set by the 7-stage
// pipeline that advances every clock; the widest step is one 31x31 square per stage.
// Stall: the pipeline keeps running into a 16-entry output buffer. A credit counter
// allows at most 10 items in pipeline and buffer together; in_stall_o rises when all
// credits are used, so nothing is lost or repeated while the receiver stalls.
// Reset: asynchronous, active low. Empties pipeline and buffer, loads the register
// reset values (cosine 1.0, everything else 0, shape none). No clearing pass.
`default_nettype none

module rotated_shape_occlusion_mask #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 14
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  rsom_pkg::pix_in_t                       in_item_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output rsom_pkg::pix_out_t                      out_item_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [rsom_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [rsom_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import rsom_pkg::*;

  cfg_t  cfg_q, cfg_d;
  logic  in_acc, out_pop;
  logic [CREDIT_W-1:0] credit_q, credit_d;

  logic              rot_valid;
  logic [MAG_W-1:0]  rot_arx, rot_ary;
  pix_out_t          rot_pix;
  logic              shp_valid;
  pix_out_t          shp_pix;

  // Register file
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SHAPE_KIND: cfg_d.shape_kind = cfg_data_i[KIND_W-1:0];
        CFG_ORIGIN_X:   cfg_d.origin_x   = cfg_data_i[ORG_W-1:0];
        CFG_ORIGIN_Y:   cfg_d.origin_y   = cfg_data_i[ORG_W-1:0];
        CFG_ROT_COS:    cfg_d.rot_cos    = cfg_data_i[TRIG_W-1:0];
        CFG_ROT_SIN:    cfg_d.rot_sin    = cfg_data_i[TRIG_W-1:0];
        CFG_SIZE_A:     cfg_d.size_a     = cfg_data_i[SIZE_W-1:0];
        CFG_SIZE_B:     cfg_d.size_b     = cfg_data_i[SIZE_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{shape_kind: SHAPE_NONE, origin_x: '0, origin_y: '0,
                 rot_cos: ROT_COS_RESET, rot_sin: '0, size_a: '0, size_b: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  // Credits: items accepted but not yet taken by the receiver
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_pop  = out_valid_o && !out_stall_i;
  assign credit_d = credit_q + CREDIT_W'(in_acc) - CREDIT_W'(out_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else begin
      credit_q <= credit_d;
    end
  end

  assign in_stall_o = (credit_q == CREDITS);

  rsom_rotate #(
    .COORD_BITS (COORD_BITS)
  ) u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_acc),
    .item_i  (in_item_i),
    .cfg_i   (cfg_q),
    .valid_o (rot_valid),
    .arx_o   (rot_arx),
    .ary_o   (rot_ary),
    .pix_o   (rot_pix)
  );

  rsom_shape #(
    .FRAC_BITS (FRAC_BITS)
  ) u_shape (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rot_valid),
    .arx_i   (rot_arx),
    .ary_i   (rot_ary),
    .pix_i   (rot_pix),
    .cfg_i   (cfg_q),
    .valid_o (shp_valid),
    .pix_o   (shp_pix)
  );

  rsom_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (shp_valid),
    .data_i  (shp_pix),
    .pop_i   (out_pop),
    .valid_o (out_valid_o),
    .data_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ===== sv/rsom_rotate.sv =====
`default_nettype none

// Stages 1 to 3: offset from origin, trig products, rotation and magnitude
module rsom_rotate #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  input  rsom_pkg::pix_in_t              item_i,
  input  rsom_pkg::cfg_t                 cfg_i,
  output logic                           valid_o,
  output logic [rsom_pkg::MAG_W-1:0]     arx_o,
  output logic [rsom_pkg::MAG_W-1:0]     ary_o,
  output rsom_pkg::pix_out_t             pix_o
);
  import rsom_pkg::*;

  localparam int CB_EFF = (COORD_BITS < PIX_W) ? COORD_BITS : PIX_W;
  localparam logic [PIX_W-1:0] CMASK = PIX_W'((64'd1 << CB_EFF) - 64'd1);
  localparam int RW = PROD_W + 1;

  logic [2:0] valid_q;

  logic [PIX_W-1:0]         px, py;
  logic signed [DIFF_W-1:0] dx_d, dy_d, dx_q, dy_q;
  pix_out_t                 pix1_q, pix2_q, pix3_q;

  logic signed [TRIG_W-1:0] cos_s, sin_s;
  logic signed [PROD_W-1:0] p_cx_d, p_sy_d, p_cy_d, p_sx_d;
  logic signed [PROD_W-1:0] p_cx_q, p_sy_q, p_cy_q, p_sx_q;

  logic signed [RW-1:0] rx, ry;
  logic [RW-1:0]        rx_neg, ry_neg;
  logic [MAG_W-1:0]     arx_d, ary_d, arx_q, ary_q;

  // Stage 1: pixel minus origin
  always_comb begin
    px   = item_i.pix_x & CMASK;
    py   = item_i.pix_y & CMASK;
    dx_d = $signed({{(DIFF_W-PIX_W){1'b0}}, px})
         - $signed({{(DIFF_W-ORG_W){cfg_i.origin_x[ORG_W-1]}}, cfg_i.origin_x});
    dy_d = $signed({{(DIFF_W-PIX_W){1'b0}}, py})
         - $signed({{(DIFF_W-ORG_W){cfg_i.origin_y[ORG_W-1]}}, cfg_i.origin_y});
  end

  // Stage 2: four signed products
  always_comb begin
    cos_s  = $signed(cfg_i.rot_cos);
    sin_s  = $signed(cfg_i.rot_sin);
    p_cx_d = cos_s * dx_q;
    p_sy_d = sin_s * dy_q;
    p_cy_d = cos_s * dy_q;
    p_sx_d = sin_s * dx_q;
  end

  // Stage 3: rotated coordinates and their magnitudes
  always_comb begin
    rx = $signed({p_cx_q[PROD_W-1], p_cx_q}) + $signed({p_sy_q[PROD_W-1], p_sy_q});
    ry = $signed({p_cy_q[PROD_W-1], p_cy_q}) - $signed({p_sx_q[PROD_W-1], p_sx_q});
    rx_neg = -rx;
    ry_neg = -ry;
    arx_d  = rx[RW-1] ? rx_neg[MAG_W-1:0] : rx[MAG_W-1:0];
    ary_d  = ry[RW-1] ? ry_neg[MAG_W-1:0] : ry[MAG_W-1:0];
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  // Data registers
  always_ff @(posedge clk_i) begin
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    pix1_q <= '{out_red: item_i.in_red, out_green: item_i.in_green,
                out_blue: item_i.in_blue, out_mask: item_i.in_mask};
    p_cx_q <= p_cx_d;
    p_sy_q <= p_sy_d;
    p_cy_q <= p_cy_d;
    p_sx_q <= p_sx_d;
    pix2_q <= pix1_q;
    arx_q  <= arx_d;
    ary_q  <= ary_d;
    pix3_q <= pix2_q;
  end

  assign valid_o = valid_q[2];
  assign arx_o   = arx_q;
  assign ary_o   = ary_q;
  assign pix_o   = pix3_q;

endmodule

`default_nettype wire

// ===== sv/rsom_shape.sv =====
`default_nettype none

// Stages 4 to 7: squares, shape compares and the covered pixel mux
module rsom_shape #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  input  wire logic [rsom_pkg::MAG_W-1:0] arx_i,
  input  wire logic [rsom_pkg::MAG_W-1:0] ary_i,
  input  rsom_pkg::pix_out_t             pix_i,
  input  rsom_pkg::cfg_t                 cfg_i,
  output logic                           valid_o,
  output rsom_pkg::pix_out_t             pix_o
);
  import rsom_pkg::*;

  // Compare widths
  localparam int BAR_W  = ((MAG_W + 1) > (SIZE_W + FRAC_BITS)) ? (MAG_W + 1)
                                                               : (SIZE_W + FRAC_BITS);
  localparam int CIR_W  = ((SQ_W + 1) > (SSQ_W + 2 * FRAC_BITS)) ? (SQ_W + 1)
                                                                 : (SSQ_W + 2 * FRAC_BITS);
  localparam int PP_W   = MAG_W + SSQ_W;
  localparam int TERM_W = SQ_W + SSQ_W;
  localparam int ELL_W  = ((TERM_W + 1) > (2 * SSQ_W + 2 * FRAC_BITS)) ? (TERM_W + 1)
                                                                      : (2 * SSQ_W + 2 * FRAC_BITS);

  logic [3:0] valid_q;

  // Stage 4 signals
  logic [SQ_W-1:0]   sx_d, sy_d, sx_q, sy_q;
  logic [SSQ_W-1:0]  asq_d, bsq_d, asq_q, bsq_q;
  logic [BAR_W-1:0]  half, twice_x, twice_y;
  logic              bar_x_d, bar_y_d, bar_x4_q, bar_y4_q;
  pix_out_t          pix4_q;

  // Stage 5 signals
  logic [CIR_W-1:0]  cir_lhs, cir_rhs;
  logic              circ_d, circ5_q, bar_x5_q, bar_y5_q;
  logic [PP_W-1:0]   e_xh_d, e_xl_d, e_yh_d, e_yl_d;
  logic [PP_W-1:0]   e_xh_q, e_xl_q, e_yh_q, e_yl_q;
  logic [2*SSQ_W-1:0] ab_d, ab_q;
  pix_out_t          pix5_q;

  // Stage 6 signals
  logic [TERM_W-1:0] t1_d, t2_d, t1_q, t2_q;
  logic [ELL_W-1:0]  ell_rhs_d, ell_rhs_q;
  logic              circ6_q, bar_x6_q, bar_y6_q;
  pix_out_t          pix6_q;

  // Stage 7 signals
  logic [ELL_W-1:0]  ell_lhs;
  logic              ell_in, covered;
  pix_out_t          pix7_d, pix7_q;

  // Stage 4: squares of the rotated magnitudes, bar limits
  always_comb begin
    sx_d    = SQ_W'(arx_i) * SQ_W'(arx_i);
    sy_d    = SQ_W'(ary_i) * SQ_W'(ary_i);
    asq_d   = SSQ_W'(cfg_i.size_a) * SSQ_W'(cfg_i.size_a);
    bsq_d   = SSQ_W'(cfg_i.size_b) * SSQ_W'(cfg_i.size_b);
    half    = BAR_W'(cfg_i.size_a) << FRAC_BITS;
    twice_x = BAR_W'({arx_i, 1'b0});
    twice_y = BAR_W'({ary_i, 1'b0});
    bar_x_d = twice_x <= half;
    bar_y_d = twice_y <= half;
  end

  // Stage 5: circle compare, ellipse partial products split at MAG_W
  always_comb begin
    cir_lhs = CIR_W'(sx_q) + CIR_W'(sy_q);
    cir_rhs = CIR_W'(asq_q) << (2 * FRAC_BITS);
    circ_d  = cir_lhs <= cir_rhs;
    e_xh_d  = PP_W'(sx_q[SQ_W-1:MAG_W]) * PP_W'(bsq_q);
    e_xl_d  = PP_W'(sx_q[MAG_W-1:0])    * PP_W'(bsq_q);
    e_yh_d  = PP_W'(sy_q[SQ_W-1:MAG_W]) * PP_W'(asq_q);
    e_yl_d  = PP_W'(sy_q[MAG_W-1:0])    * PP_W'(asq_q);
    ab_d    = (2*SSQ_W)'(asq_q) * (2*SSQ_W)'(bsq_q);
  end

  // Stage 6: assemble the two ellipse terms
  always_comb begin
    t1_d      = (TERM_W'(e_xh_q) << MAG_W) + TERM_W'(e_xl_q);
    t2_d      = (TERM_W'(e_yh_q) << MAG_W) + TERM_W'(e_yl_q);
    ell_rhs_d = ELL_W'(ab_q) << (2 * FRAC_BITS);
  end

  // Stage 7: ellipse compare and the shape select
  always_comb begin
    ell_lhs = ELL_W'(t1_q) + ELL_W'(t2_q);
    ell_in  = (ell_lhs <= ell_rhs_q) && (cfg_i.size_a != '0) && (cfg_i.size_b != '0);
    case (cfg_i.shape_kind)
      SHAPE_NONE:    covered = 1'b0;
      SHAPE_BAR:     covered = bar_x6_q;
      SHAPE_CIRCLE:  covered = circ6_q;
      SHAPE_ELLIPSE: covered = ell_in;
      SHAPE_SQUARE:  covered = bar_x6_q && bar_y6_q;
      default:       covered = 1'b0;
    endcase
    pix7_d = pix6_q;
    if (pix6_q.out_mask && covered) begin
      pix7_d = '0;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  // Data registers
  always_ff @(posedge clk_i) begin
    sx_q      <= sx_d;
    sy_q      <= sy_d;
    asq_q     <= asq_d;
    bsq_q     <= bsq_d;
    bar_x4_q  <= bar_x_d;
    bar_y4_q  <= bar_y_d;
    pix4_q    <= pix_i;
    circ5_q   <= circ_d;
    bar_x5_q  <= bar_x4_q;
    bar_y5_q  <= bar_y4_q;
    e_xh_q    <= e_xh_d;
    e_xl_q    <= e_xl_d;
    e_yh_q    <= e_yh_d;
    e_yl_q    <= e_yl_d;
    ab_q      <= ab_d;
    pix5_q    <= pix4_q;
    t1_q      <= t1_d;
    t2_q      <= t2_d;
    ell_rhs_q <= ell_rhs_d;
    circ6_q   <= circ5_q;
    bar_x6_q  <= bar_x5_q;
    bar_y6_q  <= bar_y5_q;
    pix6_q    <= pix5_q;
    pix7_q    <= pix7_d;
  end

  assign valid_o = valid_q[3];
  assign pix_o   = pix7_q;

endmodule

`default_nettype wire

// ===== sv/rsom_out_fifo.sv =====
`default_nettype none

// Output buffer: absorbs the items still in the pipeline while the receiver stalls
module rsom_out_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  rsom_pkg::pix_out_t data_i,
  input  wire logic          pop_i,
  output logic               valid_o,
  output rsom_pkg::pix_out_t data_o
);
  import rsom_pkg::*;

  localparam int DEPTH = 1 << FIFO_AW;

  pix_out_t           mem_q [DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]   count_q, count_d;
  logic               out_free, mem_rd, mem_wr, bypass;
  logic               out_vld_q, out_vld_d;
  pix_out_t           out_q;

  // Output register refills from storage first, else straight from the pipeline
  always_comb begin
    out_free  = !out_vld_q || pop_i;
    mem_rd    = out_free && (count_q != '0);
    bypass    = out_free && (count_q == '0) && push_i;
    mem_wr    = push_i && !bypass;
    out_vld_d = out_vld_q;
    if (out_free) begin
      out_vld_d = mem_rd || bypass;
    end
    count_d = count_q + (FIFO_AW+1)'(mem_wr) - (FIFO_AW+1)'(mem_rd);
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (mem_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (mem_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q   <= count_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Storage and registered read
  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      mem_q[wr_ptr_q] <= data_i;
    end
    if (mem_rd) begin
      out_q <= mem_q[rd_ptr_q];
    end else if (bypass) begin
      out_q <= data_i;
    end
  end

  assign valid_o = out_vld_q;
  assign data_o  = out_q;

endmodule

`default_nettype wire

// ===== sv/rsom_checker.sv =====
`default_nettype none

module rsom_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         in_stall_o,
  input wire logic         out_valid_o,
  input wire logic         out_stall_i,
  input rsom_pkg::pix_out_t out_item_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("result payload changed while stalled");

  // Input backpressure only when a result is waiting for the receiver
  a_stall_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // Reset empties the output side
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result offered right after reset");

endmodule

bind rotated_shape_occlusion_mask rsom_checker u_rsom_checker (.*);

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import rsom_pkg::*;

  localparam int FRAC          = 14;
  localparam int RANDOM_ITEMS  = 1100;
  localparam int QUIET_TAIL    = 150;
  localparam int HOLD_AFTER    = 300;
  localparam int HOLD_CYCLES   = 120;
  localparam int DRAIN_CYCLES  = 16;
  localparam int CYCLE_LIMIT   = 200000;

  // Codes the package leaves unnamed
  localparam logic [KIND_W-1:0]    KIND_UNKNOWN = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 3'd7;

  // Rotation pairs in Q1.14: axis turns, 45 deg, 30 deg and a few odd angles
  localparam int COS_SET [8] = '{16384, 0, -16384, 0, 11585, 14189, -8192, 15137};
  localparam int SIN_SET [8] = '{0, 16384, 0, -16384, 11585, 8192, 14189, -6270};

  typedef struct {
    bit                   is_write;
    logic [CFG_IDX_W-1:0] idx;
    int                   val;
    pix_in_t              pix;
    bit                   typed;
    pix_out_t             want;
  } row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  pix_in_t               in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  pix_out_t              out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Register copy used for prediction
  logic [KIND_W-1:0]        cur_kind  = SHAPE_NONE;
  logic signed [ORG_W-1:0]  cur_org_x = '0;
  logic signed [ORG_W-1:0]  cur_org_y = '0;
  logic signed [TRIG_W-1:0] cur_cos   = ROT_COS_RESET;
  logic signed [TRIG_W-1:0] cur_sin   = '0;
  logic [SIZE_W-1:0]        cur_a     = '0;
  logic [SIZE_W-1:0]        cur_b     = '0;

  pix_out_t pending_pixels[$];
  int       mismatches = 0;
  int       results_seen = 0;
  int       cycles = 0;
  bit       idle_on = 1'b1;
  int       stall_left = 0;
  bit       hold_done = 1'b0;
  bit       hold_req = 1'b0;

  rotated_shape_occlusion_mask dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shape coverage of one pixel, exact integer math at full width
  function automatic pix_out_t occlude(input pix_in_t p);
    longint       dx, dy, rx, ry;
    logic [63:0]  arx, ary, half;
    logic [127:0] sx, sy, a2, b2;
    logic         hit;
    pix_out_t     o;
    hit = 1'b0;
    dx = longint'(p.pix_x) - longint'(cur_org_x);
    dy = longint'(p.pix_y) - longint'(cur_org_y);
    rx = longint'(cur_cos) * dx + longint'(cur_sin) * dy;
    ry = longint'(cur_cos) * dy - longint'(cur_sin) * dx;
    arx = (rx < 0) ? 64'(-rx) : 64'(rx);
    ary = (ry < 0) ? 64'(-ry) : 64'(ry);
    half = 64'(cur_a) << FRAC;
    sx = 128'(arx) * 128'(arx);
    sy = 128'(ary) * 128'(ary);
    a2 = 128'(cur_a) * 128'(cur_a);
    b2 = 128'(cur_b) * 128'(cur_b);
    if (p.in_mask) begin
      case (cur_kind)
        SHAPE_BAR:     hit = (arx * 2 <= half);
        SHAPE_CIRCLE:  hit = (sx + sy <= (a2 << (2 * FRAC)));
        SHAPE_ELLIPSE: begin
          // a zero axis never covers
          if (cur_a != 0 && cur_b != 0) begin
            hit = (sx * b2 + sy * a2 <= ((a2 * b2) << (2 * FRAC)));
          end
        end
        SHAPE_SQUARE:  hit = (arx * 2 <= half) && (ary * 2 <= half);
        default:       hit = 1'b0;
      endcase
    end
    o.out_red   = hit ? 8'd0 : p.in_red;
    o.out_green = hit ? 8'd0 : p.in_green;
    o.out_blue  = hit ? 8'd0 : p.in_blue;
    o.out_mask  = hit ? 1'b0 : p.in_mask;
    return o;
  endfunction

  function automatic row_t write_row(input logic [CFG_IDX_W-1:0] idx, input int val);
    row_t r;
    r = '{default: '0};
    r.is_write = 1'b1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic row_t pixel_row(input int x, input int y, input bit m,
                                     input int r8, input int g8, input int b8);
    row_t r;
    r = '{default: '0};
    r.pix.pix_x    = PIX_W'(x);
    r.pix.pix_y    = PIX_W'(y);
    r.pix.in_mask  = m;
    r.pix.in_red   = COL_W'(r8);
    r.pix.in_green = COL_W'(g8);
    r.pix.in_blue  = COL_W'(b8);
    return r;
  endfunction

  function automatic row_t known_row(input int x, input int y, input bit m,
                                     input int r8, input int g8, input int b8,
                                     input int er, input int eg, input int eb, input bit em);
    row_t r;
    r = pixel_row(x, y, m, r8, g8, b8);
    r.typed = 1'b1;
    r.want.out_red   = COL_W'(er);
    r.want.out_green = COL_W'(eg);
    r.want.out_blue  = COL_W'(eb);
    r.want.out_mask  = em;
    return r;
  endfunction

  // Offer one pixel; valid stays up across back-to-back items
  task automatic send_pixel(input pix_in_t p, input pix_out_t want);
    cfg_valid <= 1'b0;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= p;
    do @(negedge clk_i); while (in_stall);
    @(posedge clk_i);
    pending_pixels.push_back(want);
  endtask

  // Register write once the pipeline has drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'(val);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(negedge clk_i); while (!cfg_ready);
    @(posedge clk_i);
    case (idx)
      CFG_SHAPE_KIND: cur_kind  = d[KIND_W-1:0];
      CFG_ORIGIN_X:   cur_org_x = d[ORG_W-1:0];
      CFG_ORIGIN_Y:   cur_org_y = d[ORG_W-1:0];
      CFG_ROT_COS:    cur_cos   = d[TRIG_W-1:0];
      CFG_ROT_SIN:    cur_sin   = d[TRIG_W-1:0];
      CFG_SIZE_A:     cur_a     = d[SIZE_W-1:0];
      CFG_SIZE_B:     cur_b     = d[SIZE_W-1:0];
      default:        ;
    endcase
  endtask

  // Output side: random stall bursts plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      hold_done  <= 1'b0;
    end else if (!hold_done && hold_req && results_seen >= HOLD_AFTER && in_valid) begin
      hold_done  <= 1'b1;
      stall_left <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result check, sampled mid-cycle ahead of the accepting edge
  always @(negedge clk_i) begin
    pix_out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      results_seen++;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item, got %h", $time, out_item);
      end else begin
        want = pending_pixels.pop_front();
        if (out_item.out_red !== want.out_red)
          $display("%0t: red expected %0d, got %0d", $time, want.out_red, out_item.out_red);
        if (out_item.out_green !== want.out_green)
          $display("%0t: green expected %0d, got %0d", $time, want.out_green,
                   out_item.out_green);
        if (out_item.out_blue !== want.out_blue)
          $display("%0t: blue expected %0d, got %0d", $time, want.out_blue, out_item.out_blue);
        if (out_item.out_mask !== want.out_mask)
          $display("%0t: mask expected %0d, got %0d", $time, want.out_mask, out_item.out_mask);
        if (out_item !== want) mismatches++;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    row_t    plan[$];
    pix_in_t p;
    int      n_sent, phase_len, span, cx, cy, pick;

    // Directed rows: pass-through at reset, edges of each shape, extremes
    plan.push_back(known_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(known_row(4095, 4095, 1, 255, 255, 255, 255, 255, 255, 1));
    plan.push_back(known_row(0, 0, 1, 'hA5, 'h5A, 'h3C, 'hA5, 'h5A, 'h3C, 1));
    // zero-width bar covers only the origin column
    plan.push_back(write_row(CFG_SHAPE_KIND, int'(SHAPE_BAR)));
    plan.push_back(known_row(0, 1234, 1, 10, 20, 30, 0, 0, 0, 0));
    plan.push_back(known_row(1, 1234, 1, 10, 20, 30, 10, 20, 30, 1));
    plan.push_back(known_row(0, 1234, 0, 10, 20, 30, 10, 20, 30, 0));
    plan.push_back(write_row(CFG_SIZE_A, 10));
    plan.push_back(known_row(5, 77, 1, 1, 2, 3, 0, 0, 0, 0));
    plan.push_back(known_row(6, 77, 1, 1, 2, 3, 1, 2, 3, 1));
    plan.push_back(write_row(CFG_SHAPE_KIND, int'(SHAPE_SQUARE)));
    plan.push_back(pixel_row(5, 5, 1, 4, 5, 6));
    plan.push_back(pixel_row(5, 6, 1, 4, 5, 6));
    plan.push_back(write_row(CFG_SHAPE_KIND, int'(SHAPE_CIRCLE)));
    plan.push_back(write_row(CFG_ORIGIN_X, 100));
    plan.push_back(write_row(CFG_ORIGIN_Y, 100));
    plan.push_back(write_row(CFG_SIZE_A, 20));
    plan.push_back(pixel_row(120, 100, 1, 7, 8, 9));
    plan.push_back(pixel_row(121, 100, 1, 7, 8, 9));
    plan.push_back(pixel_row(114, 114, 1, 7, 8, 9));
    plan.push_back(pixel_row(115, 115, 1, 7, 8, 9));
    // ellipse with a zero axis lets everything through
    plan.push_back(write_row(CFG_SHAPE_KIND, int'(SHAPE_ELLIPSE)));
    plan.push_back(known_row(100, 100, 1, 9, 9, 9, 9, 9, 9, 1));
    plan.push_back(write_row(CFG_SIZE_B, 5));
    plan.push_back(write_row(CFG_ROT_COS, 0));
    plan.push_back(write_row(CFG_ROT_SIN, 16384));
    plan.push_back(pixel_row(100, 100, 1, 11, 12, 13));
    plan.push_back(pixel_row(100, 120, 1, 11, 12, 13));
    plan.push_back(pixel_row(105, 100, 1, 11, 12, 13));
    plan.push_back(write_row(CFG_SIZE_A, 0));
    plan.push_back(known_row(100, 100, 1, 7, 7, 7, 7, 7, 7, 1));
    // unknown shape code passes, unused index changes nothing
    plan.push_back(write_row(CFG_SHAPE_KIND, int'(KIND_UNKNOWN)));
    plan.push_back(write_row(CFG_UNUSED, 'hFFFF));
    plan.push_back(known_row(0, 0, 1, 50, 60, 70, 50, 60, 70, 1));
    // register extremes
    plan.push_back(write_row(CFG_SHAPE_KIND, int'(SHAPE_SQUARE)));
    plan.push_back(write_row(CFG_ORIGIN_X, -8192));
    plan.push_back(write_row(CFG_ORIGIN_Y, 8191));
    plan.push_back(write_row(CFG_ROT_COS, -16384));
    plan.push_back(write_row(CFG_ROT_SIN, 16384));
    plan.push_back(write_row(CFG_SIZE_A, 4095));
    plan.push_back(write_row(CFG_SIZE_B, 4095));
    plan.push_back(pixel_row(4095, 0, 1, 255, 0, 255));
    plan.push_back(pixel_row(0, 4095, 1, 0, 255, 0));
    plan.push_back(pixel_row(4095, 4095, 1, 128, 64, 32));
    // trig values beyond one, used as written
    plan.push_back(write_row(CFG_SHAPE_KIND, int'(SHAPE_CIRCLE)));
    plan.push_back(write_row(CFG_ROT_COS, 32767));
    plan.push_back(write_row(CFG_ROT_SIN, -32768));
    plan.push_back(pixel_row(4095, 0, 1, 1, 1, 1));
    plan.push_back(pixel_row(0, 0, 1, 2, 2, 2));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_write)
        write_reg(plan[i].idx, plan[i].val);
      else
        send_pixel(plan[i].pix, plan[i].typed ? plan[i].want : occlude(plan[i].pix));
    end

    // Random phases: fresh shape setup, then pixels mostly around the shape
    n_sent = 0;
    while (n_sent < RANDOM_ITEMS) begin
      write_reg(CFG_SHAPE_KIND, ($urandom_range(0, 3) == 0) ?
                int'($urandom_range(0, 7)) : int'($urandom_range(1, 4)));
      for (int k = 0; k < 2; k++) begin
        pick = $urandom_range(0, 9);
        write_reg(k == 0 ? CFG_ORIGIN_X : CFG_ORIGIN_Y,
                  pick < 8 ? int'($urandom_range(0, 4095)) :
                  pick == 8 ? int'($urandom_range(0, 16383)) - 8192 :
                  ($urandom_range(0, 1) ? 8191 : -8192));
      end
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        cx = $urandom_range(0, 7);
        write_reg(CFG_ROT_COS, COS_SET[cx]);
        write_reg(CFG_ROT_SIN, SIN_SET[cx]);
      end else if (pick < 9) begin
        write_reg(CFG_ROT_COS, int'($urandom_range(0, 32768)) - 16384);
        write_reg(CFG_ROT_SIN, int'($urandom_range(0, 32768)) - 16384);
      end else begin
        write_reg(CFG_ROT_COS, int'($urandom_range(0, 65535)));
        write_reg(CFG_ROT_SIN, int'($urandom_range(0, 65535)));
      end
      for (int k = 0; k < 2; k++) begin
        pick = $urandom_range(0, 9);
        write_reg(k == 0 ? CFG_SIZE_A : CFG_SIZE_B,
                  pick < 7 ? int'($urandom_range(0, 300)) :
                  pick < 9 ? int'($urandom_range(0, 4095)) :
                  ($urandom_range(0, 1) ? 4095 : 0));
      end
      if ($urandom_range(0, 7) == 0)
        write_reg(CFG_UNUSED, int'($urandom_range(0, 65535)));

      // long hold-off starts at the head of a phase, so items keep coming
      if (n_sent >= HOLD_AFTER) hold_req = 1'b1;
      phase_len = $urandom_range(30, 90);
      for (int i = 0; i < phase_len && n_sent < RANDOM_ITEMS; i++) begin
        if (n_sent == RANDOM_ITEMS - QUIET_TAIL) idle_on <= 1'b0;
        p = pix_in_t'({$urandom, $urandom});
        p.in_mask = ($urandom_range(0, 7) != 0);
        if ($urandom_range(0, 9) < 6) begin
          span = int'(cur_a) + int'(cur_b) + 4;
          cx = int'(cur_org_x) + int'($urandom_range(0, 2 * span)) - span;
          cy = int'(cur_org_y) + int'($urandom_range(0, 2 * span)) - span;
          p.pix_x = PIX_W'((cx < 0) ? 0 : (cx > 4095) ? 4095 : cx);
          p.pix_y = PIX_W'((cy < 0) ? 0 : (cy > 4095) ? 4095 : cy);
        end
        send_pixel(p, occlude(p));
        n_sent++;
      end
    end

    // Drain and settle
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
